@@ src/multiset_rule_rewriter_core_defines.svh @@
// Assertion macros shared by the rewriter modules.
`ifndef MULTISET_RULE_REWRITER_CORE_DEFINES_SVH
`define MULTISET_RULE_REWRITER_CORE_DEFINES_SVH

// Checks that an implication holds at every clock edge outside reset.
`define MRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ src/mrr_pkg.sv @@
// ----------------------------------------------------------------------------
// Rewriter package
// Operation codes, controller commands and shared types.
// ----------------------------------------------------------------------------
package mrr_pkg;
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_RUN   = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic CFG_RULES = 1'b0;
    localparam logic CFG_SYMS  = 1'b1;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic clr_all;     // clear every count
        logic scan_start;  // begin condition scan of current rule
        logic apply_start; // begin apply pass of current rule with k
        logic load_mode;   // apply with k = 1 (load facts)
    } t_cmd;

    // Datapath status returned to the controller.
    typedef struct packed {
        logic scan_done;
        logic scan_ok;     // rule has nonempty, satisfied condition
        logic scan_empty;  // rule has empty condition
        logic apply_done;
        logic clearing;    // rule tables are being zeroed after reset
    } t_stat;
endpackage

@@ src/mrr_if.sv @@
// ----------------------------------------------------------------------------
// Rewriter channels
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface mrr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [5:0]  rule_index;
    logic [4:0]  symbol_index;
    logic [7:0]  condition_count;
    logic [7:0]  product_count;
    logic [15:0] step_limit;
    modport source (output valid, operation, rule_index, symbol_index,
                    condition_count, product_count, step_limit, input ready);
    modport sink (input valid, operation, rule_index, symbol_index,
                  condition_count, product_count, step_limit, output ready);
endinterface

interface mrr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] steps_taken;
    logic [5:0]  last_rule;
    logic        halted;
    logic [31:0] count_value;
    modport source (output valid, steps_taken, last_rule, halted, count_value,
                    input ready);
    modport sink (input valid, steps_taken, last_rule, halted, count_value,
                  output ready);
endinterface

interface mrr_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [6:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/mrr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module mrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/mrr_datapath.sv @@
// ----------------------------------------------------------------------------
// Rewriter datapath
// Rule tables, symbol counts and the per-symbol scan and apply sequencing.
// ----------------------------------------------------------------------------
module mrr_datapath import mrr_pkg::*; #(
    parameter int MAX_RULES   = 64,
    parameter int MAX_SYMBOLS = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    output t_stat                          o_stat,
    input  logic [$clog2(MAX_RULES)-1:0]   i_rule,
    input  logic [$clog2(MAX_SYMBOLS):0]   i_nsyms,
    input  logic                           i_wr,
    input  logic [5:0]                     i_wr_rule,
    input  logic [4:0]                     i_wr_sym,
    input  logic [7:0]                     i_wr_cond,
    input  logic [7:0]                     i_wr_prod,
    input  logic [4:0]                     i_rd_sym,
    output logic [31:0]                    o_rd_value
);
    localparam int RW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int SW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int AW = $clog2(MAX_RULES * MAX_SYMBOLS);
    localparam int CW = COUNT_WIDTH;
    localparam logic [CW-1:0] CMAX = '1;

    // Phases of the datapath sequencer.
    localparam logic [1:0] P_IDLE  = 2'd0;
    localparam logic [1:0] P_SCAN  = 2'd1;
    localparam logic [1:0] P_APPLY = 2'd2;
    localparam logic [1:0] P_MUL   = 2'd3;

    logic [1:0]     r_ph, n_ph;
    logic [SW:0]    r_s, n_s;          // symbol issued to RAM
    logic           r_rv, n_rv;        // RAM data valid for r_sd
    logic [SW-1:0]  r_sd, n_sd;
    logic           r_any, n_any, r_bad, n_bad;
    logic [CW-1:0]  r_k, n_k;
    logic           r_ld;
    logic [CW-1:0]  r_cnt [MAX_SYMBOLS];
    logic [CW-1:0]  r_prd;             // registered k*m
    logic [CW-1:0]  r_base;            // count after condition subtraction
    logic           r_ovf;
    logic [SW-1:0]  r_msym;
    logic           r_clr_on;          // table clearing pass in progress
    logic [AW-1:0]  r_clr_addr;

    logic [AW-1:0]  w_raddr, w_waddr;
    logic [7:0]     w_cond, w_prod;
    logic           w_wen;
    logic           w_ram_we;
    logic [AW-1:0]  w_ram_waddr;
    logic [7:0]     w_ram_cond, w_ram_prod;
    logic [CW-1:0]  w_c, w_base, w_kk;
    logic [CW+7:0]  w_mul;

    // Full table address of the symbol being issued.
    assign w_raddr = AW'(({{(AW-RW){1'b0}}, i_rule} * AW'(MAX_SYMBOLS)) + AW'(r_s));
    assign w_waddr = AW'((AW'(i_wr_rule) * AW'(MAX_SYMBOLS)) + AW'(i_wr_sym));
    assign w_wen   = i_wr && (32'(i_wr_rule) < MAX_RULES) && (32'(i_wr_sym) < MAX_SYMBOLS);

    // The clearing pass owns the write port until every cell is zero.
    assign w_ram_we    = w_wen || r_clr_on;
    assign w_ram_waddr = r_clr_on ? r_clr_addr : w_waddr;
    assign w_ram_cond  = r_clr_on ? 8'd0 : i_wr_cond;
    assign w_ram_prod  = r_clr_on ? 8'd0 : i_wr_prod;

    mrr_ram #(.WIDTH(8), .DEPTH(MAX_RULES * MAX_SYMBOLS)) u_cond (
        .i_clk(i_clk), .i_we(w_ram_we), .i_waddr(w_ram_waddr), .i_wdata(w_ram_cond),
        .i_raddr(w_raddr), .o_rdata(w_cond));
    mrr_ram #(.WIDTH(8), .DEPTH(MAX_RULES * MAX_SYMBOLS)) u_prod (
        .i_clk(i_clk), .i_we(w_ram_we), .i_waddr(w_ram_waddr), .i_wdata(w_ram_prod),
        .i_raddr(w_raddr), .o_rdata(w_prod));

    // After reset, one table cell per cycle is zeroed in both tables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_on   <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_on) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MAX_RULES * MAX_SYMBOLS - 1)) begin
                r_clr_on <= 1'b0;
            end
        end
    end

    // Count and multiply of the current symbol.
    assign w_c    = r_cnt[r_sd];
    assign w_base = (w_cond != 8'd0 && !r_ld) ? w_c - r_k : w_c;
    assign w_kk   = r_ld ? CW'(1) : r_k;
    assign w_mul  = {8'd0, w_kk} * {{CW{1'b0}}, w_prod};

    // Sequencer: scan and apply passes over the symbols in use.
    always_comb begin
        n_ph  = r_ph;
        n_s   = r_s;
        n_rv  = 1'b0;
        n_sd  = r_s[SW-1:0];
        n_any = r_any;
        n_bad = r_bad;
        n_k   = r_k;
        o_stat = '0;
        o_stat.clearing = r_clr_on;
        unique case (r_ph)
            P_IDLE: begin
                if (i_cmd.scan_start || i_cmd.apply_start) begin
                    n_ph  = i_cmd.scan_start ? P_SCAN : P_APPLY;
                    n_s   = '0;
                    n_any = 1'b0;
                    n_bad = 1'b0;
                end
            end
            P_SCAN: begin
                if (r_rv && w_cond != 8'd0) begin
                    if (w_c == '0) begin
                        n_bad = 1'b1;
                    end
                    if (!r_any || w_c < r_k) begin
                        n_k = w_c;
                    end
                    n_any = 1'b1;
                end
                if (r_s < i_nsyms) begin
                    n_rv = 1'b1;
                    n_s  = r_s + 1'b1;
                end else if (!r_rv) begin
                    n_ph = P_IDLE;
                    o_stat.scan_done  = 1'b1;
                    o_stat.scan_ok    = r_any && !r_bad;
                    o_stat.scan_empty = !r_any;
                end
            end
            P_APPLY: begin
                // Each symbol is issued, read, then passed through the multiply stage before the next.
                if (r_rv) begin
                    n_ph = P_MUL;
                end else if (r_s < i_nsyms) begin
                    n_rv = 1'b1;
                    n_s  = r_s + 1'b1;
                end else begin
                    n_ph = P_IDLE;
                    o_stat.apply_done = 1'b1;
                end
            end
            P_MUL: begin
                n_ph = P_APPLY;
            end
            default: n_ph = P_IDLE;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= P_IDLE;
            r_rv  <= 1'b0;
        end else begin
            r_ph  <= n_ph;
            r_rv  <= n_rv;
        end
        r_s   <= n_s;
        r_sd  <= n_sd;
        r_any <= n_any;
        r_bad <= n_bad;
        r_k   <= n_k;
        if (i_cmd.apply_start) begin
            r_ld <= i_cmd.load_mode;
        end
        if (r_ph == P_APPLY && r_rv) begin
            r_prd  <= w_mul[CW-1:0];
            r_ovf  <= |w_mul[CW+7:CW];
            r_base <= w_base;
            r_msym <= r_sd;
        end
    end

    // Counts: clear, or saturating update after the multiply stage.
    logic [CW:0] w_sum;
    assign w_sum = {1'b0, r_base} + {1'b0, r_prd};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (r_ph == P_MUL) begin
            r_cnt[r_msym] <= (r_ovf || w_sum[CW]) ? CMAX : w_sum[CW-1:0];
        end
    end

    // Count read, low 32 bits, zero when out of range.
    always_comb begin
        o_rd_value = '0;
        if (32'(i_rd_sym) < MAX_SYMBOLS) begin
            o_rd_value = 32'(r_cnt[i_rd_sym[SW-1:0]]);
        end
    end

    `include "multiset_rule_rewriter_core_defines.svh"
    `MRR_ASSERT_IMP(a_scan_done_idle, i_clk, i_rst_n, o_stat.scan_done, r_ph == P_SCAN)
    `MRR_ASSERT_IMP(a_ok_excl, i_clk, i_rst_n, o_stat.scan_ok, !o_stat.scan_empty)
    `MRR_ASSERT_NEXT(a_mul_follows, i_clk, i_rst_n, r_ph == P_APPLY && r_rv, r_ph == P_MUL)
endmodule

@@ src/mrr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Rewriter controller
// Sequences operations, rule scans, steps and the result handshake.
// ----------------------------------------------------------------------------
module mrr_ctrl import mrr_pkg::*; #(
    parameter int MAX_RULES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  logic [2:0]                   i_op,
    input  logic [15:0]                  i_step_limit,
    input  logic [6:0]                   i_rules,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_ready,
    output logic [31:0]                  o_steps,
    output logic [5:0]                   o_last,
    output logic                         o_halted,
    output logic                         o_wr,
    output logic                         o_rd_cap,
    output t_cmd                         o_cmd,
    input  t_stat                        i_stat,
    output logic [$clog2(MAX_RULES)-1:0] o_rule
);
    localparam int RW = $clog2(MAX_RULES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_WSCAN = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_WAPP  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]    r_st, n_st;
    logic          r_load, n_load;
    logic [RW:0]   r_r, n_r;
    logic [16:0]   r_lim, n_lim;
    logic [16:0]   r_cnt, n_cnt;
    logic [5:0]    r_last, n_last;
    logic          r_halt, n_halt;
    logic [RW:0]   w_nr;
    logic          w_acc;

    assign w_nr = (32'(i_rules) > MAX_RULES) ? (RW+1)'(MAX_RULES) : (RW+1)'(i_rules);
    // No request is taken while the tables are still being cleared.
    assign o_req_ready = (r_st == S_IDLE) && !i_stat.clearing;
    assign w_acc  = i_req_valid && o_req_ready;
    assign o_rsp_valid = (r_st == S_RESP);
    assign o_rule = r_r[RW-1:0];
    assign o_steps = 32'(r_cnt);
    assign o_last = r_last;
    assign o_halted = r_halt;
    assign o_wr = w_acc && i_op == OP_WRITE;
    assign o_rd_cap = w_acc && i_op == OP_READ;

    // Next-state logic.
    always_comb begin
        n_st = r_st; n_load = r_load; n_r = r_r; n_lim = r_lim;
        n_cnt = r_cnt; n_last = r_last; n_halt = r_halt;
        o_cmd = '0;
        unique case (r_st)
            S_IDLE: begin
                if (w_acc) begin
                    n_cnt = '0; n_last = '0; n_halt = 1'b0; n_r = '0;
                    n_lim = (i_step_limit == 16'd0) ? 17'h10000 : {1'b0, i_step_limit};
                    n_load = (i_op == OP_LOAD);
                    n_st = S_RESP;
                    if (i_op == OP_CLEAR) begin
                        o_cmd.clr_all = 1'b1;
                    end else if (i_op == OP_LOAD || i_op == OP_RUN) begin
                        n_st = S_SCAN;
                        if (i_op == OP_RUN) begin
                            n_cnt = 17'd1;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_r >= w_nr) begin
                    // No further rule: load ends, a run step fails.
                    n_st = S_RESP;
                    n_halt = !r_load;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_st = S_WSCAN;
                end
            end
            S_WSCAN: begin
                if (i_stat.scan_done) begin
                    if (r_load ? i_stat.scan_empty : i_stat.scan_ok) begin
                        n_st = S_APPLY;
                    end else begin
                        n_r = r_r + 1'b1;
                        n_st = S_SCAN;
                    end
                end
            end
            S_APPLY: begin
                o_cmd.apply_start = 1'b1;
                o_cmd.load_mode = r_load;
                n_st = S_WAPP;
            end
            S_WAPP: begin
                if (i_stat.apply_done) begin
                    if (r_load) begin
                        n_r = r_r + 1'b1;
                        n_st = S_SCAN;
                    end else begin
                        n_last = 6'(r_r);
                        n_r = '0;
                        if (r_cnt >= r_lim) begin
                            n_st = S_RESP;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                            n_st = S_SCAN;
                        end
                    end
                end
            end
            S_RESP: begin
                if (i_rsp_ready) begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_load <= n_load; r_r <= n_r; r_lim <= n_lim;
        r_cnt <= n_cnt; r_last <= n_last; r_halt <= n_halt;
    end

    `include "multiset_rule_rewriter_core_defines.svh"
    `MRR_ASSERT_IMP(a_steps_bound, i_clk, i_rst_n, r_st == S_RESP, r_cnt <= 17'h10000)
    `MRR_ASSERT_IMP(a_halt_run, i_clk, i_rst_n, r_st == S_RESP && r_halt, !r_load)
    `MRR_ASSERT_NEXT(a_acc_leaves, i_clk, i_rst_n, w_acc, r_st != S_IDLE)
endmodule

@@ src/multiset_rule_rewriter_core.sv @@
// ----------------------------------------------------------------------------
// Multiset rule rewriter core
// Rule table engine: cell writes, fact load, run, count read and clear.
// ----------------------------------------------------------------------------
// Write, read, clear and unused codes respond the cycle after the request is
// taken; a new request is taken only once the response has been accepted.
// Load and each run step scan the rules in use in order; a fired or loaded
// rule then runs an apply pass over every symbol in use.
// Synchronous active-low reset clears counts, registers and control, then both
// tables are zeroed cell by cell with no request taken.
module multiset_rule_rewriter_core import mrr_pkg::*; #(
    parameter int MAX_RULES   = 64,
    parameter int MAX_SYMBOLS = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mrr_req_if.sink   req,
    mrr_rsp_if.source rsp,
    mrr_cfg_if.sink   cfg
);
    localparam int RW = $clog2(MAX_RULES);
    localparam int SW = $clog2(MAX_SYMBOLS);

    logic [6:0]    r_rules;
    logic [5:0]    r_syms;
    logic [31:0]   r_rd, w_rd;
    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [RW-1:0] w_rule;
    logic          w_wr, w_rd_cap;
    logic [SW:0]   w_nsyms;

    // Register writes.
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rules <= '0;
            r_syms  <= '0;
        end else if (cfg.valid) begin
            if (cfg.index == CFG_RULES) begin
                r_rules <= cfg.data;
            end else begin
                r_syms <= cfg.data[5:0];
            end
        end
    end
    assign w_nsyms = (32'(r_syms) > MAX_SYMBOLS) ? (SW+1)'(MAX_SYMBOLS) : (SW+1)'(r_syms);

    mrr_ctrl #(.MAX_RULES(MAX_RULES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req.valid), .o_req_ready(req.ready),
        .i_op(req.operation), .i_step_limit(req.step_limit), .i_rules(r_rules),
        .o_rsp_valid(rsp.valid), .i_rsp_ready(rsp.ready),
        .o_steps(rsp.steps_taken), .o_last(rsp.last_rule), .o_halted(rsp.halted),
        .o_wr(w_wr), .o_rd_cap(w_rd_cap), .o_cmd(w_cmd), .i_stat(w_stat),
        .o_rule(w_rule));

    mrr_datapath #(.MAX_RULES(MAX_RULES), .MAX_SYMBOLS(MAX_SYMBOLS),
                   .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_rule(w_rule), .i_nsyms(w_nsyms), .i_wr(w_wr),
        .i_wr_rule(req.rule_index), .i_wr_sym(req.symbol_index),
        .i_wr_cond(req.condition_count), .i_wr_prod(req.product_count),
        .i_rd_sym(req.symbol_index), .o_rd_value(w_rd));

    // Read result captured at request; zero for other operations.
    always_ff @(posedge i_clk) begin
        if (req.valid && req.ready) begin
            r_rd <= w_rd_cap ? w_rd : 32'd0;
        end
    end
    assign rsp.count_value = r_rd;
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiset rule rewriter testbench
// Runs a short table of directed requests and random request streams under
// several rule and symbol settings. A built-in rewriting predictor produces
// the expected response of each random request and untyped table row; typed
// rows carry their own. Each response is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import mrr_pkg::*;

    typedef struct {
        logic [2:0]  op;
        logic [5:0]  ri;
        logic [4:0]  si;
        logic [7:0]  cc;
        logic [7:0]  pc;
        logic [15:0] ms;
    } t_request;

    typedef struct {
        logic [31:0] steps;
        logic [5:0]  last;
        logic        halted;
        logic [31:0] value;
    } t_outcome;

    typedef struct {
        t_request    rq;
        bit          typed;
        logic [31:0] want_value;
    } t_stim_row;

    localparam int NUM_RULES   = 64;
    localparam int NUM_SYMBOLS = 32;
    localparam int UNBOUNDED   = 65536;
    localparam int TRIAL_STEPS = 65;
    localparam int STALL_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 290;

    logic i_clk;
    logic i_rst_n;

    mrr_req_if req_ch ();
    mrr_rsp_if rsp_ch ();
    mrr_cfg_if cfg_ch ();

    multiset_rule_rewriter_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .cfg     (cfg_ch)
    );

    // Predictor state.
    logic [7:0]  cond_tab [NUM_RULES][NUM_SYMBOLS];
    logic [7:0]  prod_tab [NUM_RULES][NUM_SYMBOLS];
    logic [31:0] sym_counts [NUM_SYMBOLS];
    logic [6:0]  rules_reg;
    logic [5:0]  syms_reg;

    t_outcome  pending_q [$];
    t_stim_row dir_rows [$];
    int        mismatches;
    int        stall_cycles;
    int        send_idle;
    int        recv_idle;

    // Clock.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int rules_in_use();
        return (rules_reg > NUM_RULES) ? NUM_RULES : int'(rules_reg);
    endfunction

    function automatic int syms_in_use();
        return (syms_reg > NUM_SYMBOLS) ? NUM_SYMBOLS : int'(syms_reg);
    endfunction

    function automatic logic [31:0] sat_grow(logic [31:0] c, logic [31:0] k, logic [7:0] m);
        logic [63:0] sum;
        sum = 64'(c) + 64'(k) * 64'(m);
        return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // One rewriting step: fires the first satisfied rule with a nonempty condition.
    function automatic bit fire_first_rule(output int fired);
        int nr;
        int ns;
        bit any;
        bit ok;
        logic [31:0] k;
        nr = rules_in_use();
        ns = syms_in_use();
        fired = 0;
        for (int r = 0; r < nr; r++) begin
            any = 0;
            ok = 1;
            k = '0;
            for (int s = 0; s < ns; s++) begin
                if (cond_tab[r][s] == 0) continue;
                if (sym_counts[s] == 0) begin
                    ok = 0;
                    break;
                end
                if (!any || sym_counts[s] < k) k = sym_counts[s];
                any = 1;
            end
            if (!ok || !any) continue;
            for (int s = 0; s < ns; s++) begin
                if (cond_tab[r][s] != 0) sym_counts[s] = sym_counts[s] - k;
                sym_counts[s] = sat_grow(sym_counts[s], k, prod_tab[r][s]);
            end
            fired = r;
            return 1;
        end
        return 0;
    endfunction

    function automatic t_outcome run_rules(int unsigned limit);
        t_outcome o;
        int fired;
        o = '{default: '0};
        forever begin
            o.steps = o.steps + 1;
            if (fire_first_rule(fired)) begin
                o.last = 6'(fired);
            end else begin
                o.halted = 1'b1;
                break;
            end
            if (o.steps >= limit) break;
        end
        return o;
    endfunction

    // Applies one request to the predictor state and returns its response.
    function automatic t_outcome apply_request(t_request rq);
        t_outcome o;
        int nr;
        int ns;
        bit empty;
        o = '{default: '0};
        nr = rules_in_use();
        ns = syms_in_use();
        case (rq.op)
            OP_WRITE: begin
                cond_tab[rq.ri][rq.si] = rq.cc;
                prod_tab[rq.ri][rq.si] = rq.pc;
            end
            OP_LOAD: begin
                for (int r = 0; r < nr; r++) begin
                    empty = 1;
                    for (int s = 0; s < ns; s++)
                        if (cond_tab[r][s] != 0) empty = 0;
                    if (!empty) continue;
                    for (int s = 0; s < ns; s++)
                        sym_counts[s] = sat_grow(sym_counts[s], 32'd1, prod_tab[r][s]);
                end
            end
            OP_RUN: o = run_rules((rq.ms == 0) ? UNBOUNDED : int'(rq.ms));
            OP_READ: o.value = sym_counts[rq.si];
            OP_CLEAR: begin
                for (int s = 0; s < NUM_SYMBOLS; s++) sym_counts[s] = '0;
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR %0t: %s got %0h expected %0h", $realtime, field, got, want);
    endtask

    // Sends one request and records its expected response on acceptance.
    task automatic send_request(t_request rq, bit typed, logic [31:0] want_value);
        t_outcome o;
        if ($urandom_range(99) < send_idle) begin
            req_ch.valid = 1'b0;
            while ($urandom_range(99) < send_idle + 20) @(negedge i_clk);
        end
        req_ch.valid           = 1'b1;
        req_ch.operation       = rq.op;
        req_ch.rule_index      = rq.ri;
        req_ch.symbol_index    = rq.si;
        req_ch.condition_count = rq.cc;
        req_ch.product_count   = rq.pc;
        req_ch.step_limit      = rq.ms;
        do @(posedge i_clk); while (!req_ch.ready);
        o = apply_request(rq);
        if (typed) o = '{steps: '0, last: '0, halted: 1'b0, value: want_value};
        pending_q.push_back(o);
        @(negedge i_clk);
    endtask

    // Waits until every response is in and the block has settled.
    task automatic drain();
        req_ch.valid = 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [6:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CFG_RULES) rules_reg = data;
        else syms_reg = data[5:0];
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic t_request mk(logic [2:0] op, logic [5:0] ri, logic [4:0] si,
                                    logic [7:0] cc, logic [7:0] pc, logic [15:0] ms);
        t_request rq;
        rq = '{op: op, ri: ri, si: si, cc: cc, pc: pc, ms: ms};
        return rq;
    endfunction

    // Random request biased toward the rules and symbols in use.
    function automatic t_request random_request();
        t_request rq;
        int pick;
        int nr;
        int ns;
        nr = rules_in_use();
        ns = syms_in_use();
        rq = mk(3'($urandom_range(7)), 6'($urandom), 5'($urandom), 8'($urandom),
                8'($urandom), 16'($urandom));
        pick = $urandom_range(99);
        if (pick < 50) rq.op = OP_WRITE;
        else if (pick < 58) rq.op = OP_LOAD;
        else if (pick < 74) rq.op = OP_RUN;
        else if (pick < 92) rq.op = OP_READ;
        else if (pick < 96) rq.op = OP_CLEAR;
        if (nr > 0 && $urandom_range(99) < 85) rq.ri = 6'($urandom_range(nr - 1));
        if (ns > 0 && $urandom_range(99) < 85) rq.si = 5'($urandom_range(ns - 1));
        if ($urandom_range(99) < 60) rq.cc = '0;
        else if ($urandom_range(99) < 70) rq.cc = 8'($urandom_range(1, 3));
        if ($urandom_range(99) < 45) rq.pc = '0;
        else if ($urandom_range(99) < 70) rq.pc = 8'($urandom_range(1, 4));
        pick = $urandom_range(99);
        if (pick < 65) rq.ms = 16'($urandom_range(1, 6));
        else if (pick < 85) rq.ms = '0;
        return rq;
    endfunction

    // Keeps long runs short: a run that would outlast a trial gets a small limit.
    function automatic t_request bound_run(t_request rq);
        logic [31:0] saved [NUM_SYMBOLS];
        t_outcome t;
        if (rq.op != OP_RUN || (rq.ms != 0 && rq.ms < TRIAL_STEPS)) return rq;
        saved = sym_counts;
        t = run_rules(TRIAL_STEPS);
        sym_counts = saved;
        if (!t.halted) rq.ms = 16'($urandom_range(1, 8));
        return rq;
    endfunction

    // Response ready with random stalls.
    always @(negedge i_clk) begin
        rsp_ch.ready = ($urandom_range(99) >= recv_idle);
    end

    // Response checker.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected response", rsp_ch.count_value, 32'd0);
            end else begin
                want = pending_q.pop_front();
                if (rsp_ch.steps_taken !== want.steps)
                    report("steps_taken", rsp_ch.steps_taken, want.steps);
                if (rsp_ch.last_rule !== want.last)
                    report("last_rule", 32'(rsp_ch.last_rule), 32'(want.last));
                if (rsp_ch.halted !== want.halted)
                    report("halted", 32'(rsp_ch.halted), 32'(want.halted));
                if (rsp_ch.count_value !== want.value)
                    report("count_value", rsp_ch.count_value, want.value);
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("multiset_rule_rewriter_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        int plan_rules [6];
        int plan_syms [6];
        t_request rq;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_WRITE;
        req_ch.rule_index = '0;
        req_ch.symbol_index = '0;
        req_ch.condition_count = '0;
        req_ch.product_count = '0;
        req_ch.step_limit = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_RULES;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        mismatches = 0;
        stall_cycles = 0;
        send_idle = 13;
        recv_idle = 47;
        rules_reg = '0;
        syms_reg = '0;
        for (int r = 0; r < NUM_RULES; r++)
            for (int s = 0; s < NUM_SYMBOLS; s++) begin
                cond_tab[r][s] = '0;
                prod_tab[r][s] = '0;
            end
        for (int s = 0; s < NUM_SYMBOLS; s++) sym_counts[s] = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: facts, a consuming rule, saturation and unused codes.
        write_register(CFG_RULES, 7'd4);
        write_register(CFG_SYMS, 7'd4);
        dir_rows.push_back('{mk(OP_READ, 6'd0, 5'd0, 8'd0, 8'd0, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(OP_WRITE, 6'd0, 5'd0, 8'd0, 8'd255, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(OP_WRITE, 6'd0, 5'd1, 8'd0, 8'd1, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(OP_LOAD, 6'd0, 5'd0, 8'd0, 8'd0, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(OP_READ, 6'd0, 5'd0, 8'd0, 8'd0, 16'd0), 1'b1, 32'd255});
        dir_rows.push_back('{mk(OP_WRITE, 6'd1, 5'd0, 8'd255, 8'd0, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(OP_WRITE, 6'd1, 5'd2, 8'd0, 8'd3, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(OP_RUN, 6'd0, 5'd0, 8'd0, 8'd0, 16'hFFFF), 1'b0, 32'd0});
        dir_rows.push_back('{mk(OP_READ, 6'd0, 5'd2, 8'd0, 8'd0, 16'd0), 1'b0, 32'd0});
        dir_rows.push_back('{mk(OP_WRITE, 6'd63, 5'd31, 8'd255, 8'd255, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(OP_READ, 6'd0, 5'd31, 8'd0, 8'd0, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(3'd5, 6'd63, 5'd31, 8'd255, 8'd255, 16'hFFFF), 1'b1, 32'd0});
        dir_rows.push_back('{mk(3'd6, 6'd0, 5'd0, 8'd0, 8'd0, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(3'd7, 6'd63, 5'd31, 8'd255, 8'd255, 16'hFFFF), 1'b1, 32'd0});
        dir_rows.push_back('{mk(OP_CLEAR, 6'd0, 5'd0, 8'd0, 8'd0, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(OP_READ, 6'd0, 5'd0, 8'd0, 8'd0, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(OP_RUN, 6'd0, 5'd0, 8'd0, 8'd0, 16'd0), 1'b0, 32'd0});
        dir_rows.push_back('{mk(OP_LOAD, 6'd0, 5'd0, 8'd0, 8'd0, 16'd0), 1'b0, 32'd0});
        dir_rows.push_back('{mk(OP_WRITE, 6'd2, 5'd1, 8'd1, 8'd255, 16'd0), 1'b1, 32'd0});
        dir_rows.push_back('{mk(OP_RUN, 6'd0, 5'd0, 8'd0, 8'd0, 16'd6), 1'b0, 32'd0});
        dir_rows.push_back('{mk(OP_READ, 6'd0, 5'd1, 8'd0, 8'd0, 16'd0), 1'b0, 32'd0});
        dir_rows.push_back('{mk(OP_READ, 6'd0, 5'd2, 8'd0, 8'd0, 16'd0), 1'b0, 32'd0});
        foreach (dir_rows[i])
            send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want_value);
        drain();

        // Random part over several register settings, extremes included.
        plan_rules = '{64, 127, 0, 3, 10, $urandom_range(1, 16)};
        plan_syms  = '{32, 63, 0, 5, 8, $urandom_range(1, 8)};
        sent = 0;
        for (int p = 0; p < 6; p++) begin
            write_register(CFG_RULES, 7'(plan_rules[p]));
            write_register(CFG_SYMS, 7'(plan_syms[p]));
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                if (sent < RANDOM_ITEMS / 3) begin
                    send_idle = 13;
                    recv_idle = 47;
                end else if (sent < 2 * RANDOM_ITEMS / 3) begin
                    send_idle = 47;
                    recv_idle = 13;
                end else begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                rq = bound_run(random_request());
                send_request(rq, 1'b0, '0);
                sent++;
            end
            drain();
        end

        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("multiset_rule_rewriter_core: match");
        end else begin
            $display("multiset_rule_rewriter_core: mismatch");
        end
        $finish;
    end
endmodule
